@@ rtl/d2q9_trt_collision_unit_assert.svh @@
// Assertion macros for the D2Q9 TRT collision unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef D2Q9_TRT_COLLISION_UNIT_ASSERT_SVH
`define D2Q9_TRT_COLLISION_UNIT_ASSERT_SVH
// Consequent must hold in the same cycle as the antecedent.
`define D2Q9_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("d2q9 check failed");
// Consequent must hold in the cycle after the antecedent.
`define D2Q9_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("d2q9 check failed");
`endif

@@ rtl/d2q9_pkg.sv @@
// Shared constants, types and fixed-point helpers for the D2Q9 collision unit.
// No dependencies.
`default_nettype none
package d2q9_pkg;
  localparam int FRAC_BITS_DEF   = 20;
  localparam int VALUE_WIDTH_DEF = 24;
  localparam int RELAX_W         = 22;
  localparam int DIFF_W          = 21;
  localparam int ADDR_W          = 4;
  localparam int NDIR            = 9;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_RELAX_EVEN = 2'd0;
  localparam logic [1:0] REG_RELAX_ODD  = 2'd1;
  localparam logic [1:0] REG_DIFFUSION  = 2'd2;

  // Pipeline control handed to the merging stage.
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  // Opposite direction of each lattice direction.
  function automatic int opp_dir(input int d);
    int r;
    case (d)
      1: r = 3;
      2: r = 4;
      3: r = 1;
      4: r = 2;
      5: r = 7;
      6: r = 8;
      7: r = 5;
      8: r = 6;
      default: r = 0;
    endcase
    return r;
  endfunction

  // Divide by 2^n, rounding half away from zero.
  function automatic logic signed [127:0] rshr(input logic signed [127:0] x,
                                               input int n);
    logic signed [127:0] t;
    t = x + (128'sd1 <<< (n - 1)) - (x < 0 ? 128'sd1 : 128'sd0);
    return t >>> n;
  endfunction

  // Saturate to a signed vw-bit range.
  function automatic logic signed [127:0] sat_w(input logic signed [127:0] x,
                                                input int vw);
    logic signed [127:0] vmax;
    vmax = (128'sd1 <<< (vw - 1)) - 128'sd1;
    if (x > vmax) return vmax;
    if (x < -vmax - 128'sd1) return -vmax - 128'sd1;
    return x;
  endfunction
endpackage
`default_nettype wire

@@ rtl/d2q9_in_if.sv @@
// Input channel of the collision unit: one lattice node per item.
// Standalone; width follows VW.
`default_nettype none
interface d2q9_in_if #(parameter int VW = 24) ();
  logic valid;
  logic ready;
  logic signed [VW-1:0] pop_rest, pop_east, pop_north, pop_west, pop_south;
  logic signed [VW-1:0] pop_northeast, pop_northwest, pop_southwest, pop_southeast;
  logic signed [VW-1:0] vel_x, vel_y;
  modport source (output valid, pop_rest, pop_east, pop_north, pop_west, pop_south,
                  pop_northeast, pop_northwest, pop_southwest, pop_southeast,
                  vel_x, vel_y, input ready);
  modport sink (input valid, pop_rest, pop_east, pop_north, pop_west, pop_south,
                pop_northeast, pop_northwest, pop_southwest, pop_southeast,
                vel_x, vel_y, output ready);
endinterface
`default_nettype wire

@@ rtl/d2q9_out_if.sv @@
// Result channel of the collision unit: post-collision populations.
// Standalone; width follows VW.
`default_nettype none
interface d2q9_out_if #(parameter int VW = 24) ();
  logic valid;
  logic ready;
  logic signed [VW-1:0] out_rest, out_east, out_north, out_west, out_south;
  logic signed [VW-1:0] out_northeast, out_northwest, out_southwest, out_southeast;
  logic signed [VW-1:0] concentration;
  modport source (output valid, out_rest, out_east, out_north, out_west, out_south,
                  out_northeast, out_northwest, out_southwest, out_southeast,
                  concentration, input ready);
  modport sink (input valid, out_rest, out_east, out_north, out_west, out_south,
                out_northeast, out_northwest, out_southwest, out_southeast,
                concentration, output ready);
endinterface
`default_nettype wire

@@ rtl/d2q9_trt_collision_unit.sv @@
// Top level of the D2Q9 TRT collision unit: configuration registers,
// pipeline control, front end, nine lanes and the merging stage.
// Uses d2q9_pkg, d2q9_in_if, d2q9_out_if, d2q9_front/lane/merge, assertion header.
//
//   Channel   Direction  Handshake           Contents
//   in_ch     in         valid/ready         nine populations, vel_x, vel_y
//   out_ch    out        valid/ready         nine populations, concentration
//   APB       in         psel/penable/pready relax_even, relax_odd, diffusion_scale
//
// One item per cycle. The accepting edge loads the first of 11 register stages
// (7 front-end stages, 3 lane stages and the output register).
// The whole pipeline advances together; it stalls only while a finished item
// waits at the output and out_ch.ready is low.
// rst_n is synchronous; it clears the valid bits and loads register defaults.
`default_nettype none
`include "d2q9_trt_collision_unit_assert.svh"
module d2q9_trt_collision_unit #(
  parameter int FRAC_BITS   = d2q9_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = d2q9_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  d2q9_in_if.sink                           in_ch,
  d2q9_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [d2q9_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  localparam int ND    = d2q9_pkg::NDIR;
  localparam int DEPTH = 10;
  localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
  localparam logic [d2q9_pkg::RELAX_W-1:0] RE_RST =
    d2q9_pkg::RELAX_W'((ONE_Q + 50) / 100);
  localparam logic [d2q9_pkg::RELAX_W-1:0] RO_RST =
    d2q9_pkg::RELAX_W'((199 * ONE_Q + 50) / 100);
  localparam logic [d2q9_pkg::DIFF_W-1:0] CE_RST =
    d2q9_pkg::DIFF_W'((2 * ONE_Q + 3) / 6);

  // Configuration registers.
  logic [d2q9_pkg::RELAX_W-1:0] relax_even_r, relax_odd_r;
  logic [d2q9_pkg::DIFF_W-1:0]  diff_r;
  logic                         wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_even_r <= RE_RST;
      relax_odd_r  <= RO_RST;
      diff_r       <= CE_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        d2q9_pkg::REG_RELAX_EVEN: relax_even_r <= pwdata[d2q9_pkg::RELAX_W-1:0];
        d2q9_pkg::REG_RELAX_ODD:  relax_odd_r  <= pwdata[d2q9_pkg::RELAX_W-1:0];
        d2q9_pkg::REG_DIFFUSION:  diff_r       <= pwdata[d2q9_pkg::DIFF_W-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      d2q9_pkg::REG_RELAX_EVEN: prdata = 32'(relax_even_r);
      d2q9_pkg::REG_RELAX_ODD:  prdata = 32'(relax_odd_r);
      d2q9_pkg::REG_DIFFUSION:  prdata = 32'(diff_r);
      default:                  prdata = '0;
    endcase
  end

  // Pipeline control: advance unless a finished item is stalled at the output.
  logic             en;
  logic [DEPTH-1:0] vld_r;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
    end
  end

  // Front end.
  logic signed [VALUE_WIDTH-1:0] pop [ND];
  logic signed [VALUE_WIDTH-1:0] f_w [ND];
  logic signed [VALUE_WIDTH-1:0] es_w [ND];
  logic signed [VALUE_WIDTH-1:0] ea_w [ND];
  logic signed [VALUE_WIDTH-1:0] rho_w;
  logic signed [VALUE_WIDTH-1:0] lane_res [ND];
  assign pop[0] = in_ch.pop_rest;
  assign pop[1] = in_ch.pop_east;
  assign pop[2] = in_ch.pop_north;
  assign pop[3] = in_ch.pop_west;
  assign pop[4] = in_ch.pop_south;
  assign pop[5] = in_ch.pop_northeast;
  assign pop[6] = in_ch.pop_northwest;
  assign pop[7] = in_ch.pop_southwest;
  assign pop[8] = in_ch.pop_southeast;

  d2q9_front #(.FB(FRAC_BITS), .VW(VALUE_WIDTH)) u_front (
    .clk   (clk),
    .en    (en),
    .pop   (pop),
    .vel_x (in_ch.vel_x),
    .vel_y (in_ch.vel_y),
    .ce    (diff_r),
    .f_o   (f_w),
    .es_o  (es_w),
    .ea_o  (ea_w),
    .rho_o (rho_w)
  );

  // Nine relaxation lanes, one per direction.
  for (genvar k = 0; k < ND; k++) begin : g_lane
    d2q9_lane #(.FB(FRAC_BITS), .VW(VALUE_WIDTH), .IS_REST(k == 0)) u_lane (
      .clk        (clk),
      .en         (en),
      .f          (f_w[k]),
      .f_opp      (f_w[d2q9_pkg::opp_dir(k)]),
      .es         (es_w[k]),
      .ea         (ea_w[k]),
      .relax_even (relax_even_r),
      .relax_odd  (relax_odd_r),
      .res        (lane_res[k])
    );
  end

  // Merging stage and output register.
  d2q9_pkg::pipe_ctl_t mctl;
  assign mctl.en  = en;
  assign mctl.vld = vld_r[DEPTH-1];
  d2q9_merge #(.VW(VALUE_WIDTH)) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mctl),
    .lane_res (lane_res),
    .rho      (rho_w),
    .out_ch   (out_ch)
  );

  // A refused input only ever means a result is stalled at the output.
  `D2Q9_CHK_NOW(a_stall_cause, !in_ch.ready, out_ch.valid && !out_ch.ready)
  // An accepted item enters the first stage.
  `D2Q9_CHK_NEXT(a_enter, in_ch.valid && in_ch.ready, vld_r[0])
  // A taken result with nothing behind it leaves the output empty.
  `D2Q9_CHK_NEXT(a_drain, out_ch.valid && out_ch.ready && !vld_r[DEPTH-1], !out_ch.valid)
endmodule
`default_nettype wire

@@ rtl/d2q9_front.sv @@
// Equilibrium front end: concentration, velocity products and equilibria.
// Seven pipeline stages; uses d2q9_pkg.
`default_nettype none
module d2q9_front #(
  parameter int FB = d2q9_pkg::FRAC_BITS_DEF,
  parameter int VW = d2q9_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [VW-1:0]          pop [d2q9_pkg::NDIR],
  input  wire logic signed [VW-1:0]          vel_x,
  input  wire logic signed [VW-1:0]          vel_y,
  input  wire logic [d2q9_pkg::DIFF_W-1:0]   ce,
  output logic signed [VW-1:0]               f_o  [d2q9_pkg::NDIR],
  output logic signed [VW-1:0]               es_o [d2q9_pkg::NDIR],
  output logic signed [VW-1:0]               ea_o [d2q9_pkg::NDIR],
  output logic signed [VW-1:0]               rho_o
);
  localparam int EW = VW + 8;
  localparam int ND = d2q9_pkg::NDIR;
  localparam logic signed [VW-1:0] C3  = VW'((2 * (64'sd1 <<< FB) + 3) / 6);
  localparam logic signed [VW-1:0] C12 = VW'((2 * (64'sd1 <<< FB) + 12) / 24);

  function automatic logic signed [VW-1:0] sat_v(input logic signed [EW-1:0] x);
    return signed'(VW'(d2q9_pkg::sat_w(128'(x), VW)));
  endfunction

  function automatic logic signed [VW-1:0] qshr(input logic signed [EW-1:0] x,
                                                input int n);
    return signed'(VW'(d2q9_pkg::sat_w(d2q9_pkg::rshr(128'(x), n), VW)));
  endfunction

  function automatic logic signed [VW-1:0] qmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = (2*VW)'(a) * (2*VW)'(b);
    return signed'(VW'(d2q9_pkg::sat_w(d2q9_pkg::rshr(128'(p), FB), VW)));
  endfunction

  // Population delay line, stage 1 through stage 7.
  logic signed [VW-1:0] fd_r [7][ND];
  always_ff @(posedge clk) begin
    if (en) begin
      fd_r[0] <= pop;
      for (int i = 1; i < 7; i++) fd_r[i] <= fd_r[i-1];
    end
  end

  // Stage 1: velocity capture.
  logic signed [VW-1:0] ux1_r, uy1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ux1_r <= vel_x;
      uy1_r <= vel_y;
    end
  end

  // Stage 2: concentration and velocity products.
  logic signed [EW-1:0] acc;
  always_comb begin
    acc = '0;
    for (int k = 0; k < ND; k++) acc = acc + EW'(fd_r[0][k]);
  end
  logic signed [VW-1:0] rho2_r, uxx2_r, uyy2_r, uxy2_r, upx2_r, umx2_r, ux2_r, uy2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      rho2_r <= sat_v(acc);
      uxx2_r <= qmul(ux1_r, ux1_r);
      uyy2_r <= qmul(uy1_r, uy1_r);
      uxy2_r <= qmul(ux1_r, uy1_r);
      upx2_r <= sat_v(EW'(ux1_r) + EW'(uy1_r));
      umx2_r <= sat_v(EW'(uy1_r) - EW'(ux1_r));
      ux2_r  <= ux1_r;
      uy2_r  <= uy1_r;
    end
  end

  // Stage 3: base term and concentration times velocity.
  logic signed [VW-1:0] usq3;
  logic signed [VW-1:0] rho3_r, base3_r, umn3_r, uxy3_r, rux3_r, ruy3_r, rup3_r, rum3_r;
  assign usq3 = sat_v(EW'(uxx2_r) + EW'(uyy2_r));
  always_ff @(posedge clk) begin
    if (en) begin
      rho3_r  <= rho2_r;
      base3_r <= sat_v(EW'(signed'({1'b0, ce})) + EW'(qshr(EW'(usq3), 1)));
      umn3_r  <= sat_v(EW'(uxx2_r) - EW'(uyy2_r));
      uxy3_r  <= uxy2_r;
      rux3_r  <= qmul(rho2_r, ux2_r);
      ruy3_r  <= qmul(rho2_r, uy2_r);
      rup3_r  <= qmul(rho2_r, upx2_r);
      rum3_r  <= qmul(rho2_r, umx2_r);
    end
  end

  // Stage 4: scaled products.
  logic signed [VW-1:0] rho4_r, rb4_r, pmn4_r, pcr4_r, ea1_4_r, ea2_4_r, ea5_4_r, ea6_4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      rho4_r  <= rho3_r;
      rb4_r   <= qmul(rho3_r, base3_r);
      pmn4_r  <= qmul(rho3_r, umn3_r);
      pcr4_r  <= qmul(rho3_r, uxy3_r);
      ea1_4_r <= qmul(C3, rux3_r);
      ea2_4_r <= qmul(C3, ruy3_r);
      ea5_4_r <= qmul(C12, rup3_r);
      ea6_4_r <= qmul(C12, rum3_r);
    end
  end

  // Stage 5: axis and diagonal weights, antisymmetric equilibria.
  logic signed [VW-1:0] rho5_r, ax5_r, dg5_r, qmn5_r, qcr5_r;
  logic signed [VW-1:0] ea5_r [ND];
  always_ff @(posedge clk) begin
    if (en) begin
      rho5_r   <= rho4_r;
      ax5_r    <= qmul(C3, rb4_r);
      dg5_r    <= qmul(C12, rb4_r);
      qmn5_r   <= qshr(EW'(pmn4_r), 2);
      qcr5_r   <= qshr(EW'(pcr4_r), 2);
      ea5_r[0] <= '0;
      ea5_r[1] <= ea1_4_r;
      ea5_r[2] <= ea2_4_r;
      ea5_r[5] <= ea5_4_r;
      ea5_r[6] <= ea6_4_r;
      ea5_r[3] <= sat_v(-EW'(ea1_4_r));
      ea5_r[4] <= sat_v(-EW'(ea2_4_r));
      ea5_r[7] <= sat_v(-EW'(ea5_4_r));
      ea5_r[8] <= sat_v(-EW'(ea6_4_r));
    end
  end

  // Stage 6: symmetric equilibria of the moving directions.
  logic signed [VW-1:0] rho6_r, esa6_r, esb6_r, esc6_r, esd6_r;
  logic signed [VW-1:0] ea6_r [ND];
  always_ff @(posedge clk) begin
    if (en) begin
      rho6_r <= rho5_r;
      esa6_r <= sat_v(EW'(ax5_r) + EW'(qmn5_r));
      esb6_r <= sat_v(EW'(ax5_r) - EW'(qmn5_r));
      esc6_r <= sat_v(EW'(dg5_r) + EW'(qcr5_r));
      esd6_r <= sat_v(EW'(dg5_r) - EW'(qcr5_r));
      ea6_r  <= ea5_r;
    end
  end

  // Stage 7: rest equilibrium and full equilibrium vectors.
  logic signed [EW-1:0] es_sum;
  assign es_sum = EW'(esa6_r) + EW'(esb6_r) + EW'(esc6_r) + EW'(esd6_r);
  logic signed [VW-1:0] rho7_r;
  logic signed [VW-1:0] es7_r [ND];
  logic signed [VW-1:0] ea7_r [ND];
  always_ff @(posedge clk) begin
    if (en) begin
      rho7_r   <= rho6_r;
      es7_r[0] <= sat_v(EW'(rho6_r) - (es_sum <<< 1));
      es7_r[1] <= esa6_r;
      es7_r[3] <= esa6_r;
      es7_r[2] <= esb6_r;
      es7_r[4] <= esb6_r;
      es7_r[5] <= esc6_r;
      es7_r[7] <= esc6_r;
      es7_r[6] <= esd6_r;
      es7_r[8] <= esd6_r;
      ea7_r    <= ea6_r;
    end
  end

  assign f_o   = fd_r[6];
  assign es_o  = es7_r;
  assign ea_o  = ea7_r;
  assign rho_o = rho7_r;
endmodule
`default_nettype wire

@@ rtl/d2q9_lane.sv @@
// One relaxation lane: splits a direction into its parts and relaxes them.
// Three pipeline stages; uses d2q9_pkg.
`default_nettype none
module d2q9_lane #(
  parameter int FB  = d2q9_pkg::FRAC_BITS_DEF,
  parameter int VW  = d2q9_pkg::VALUE_WIDTH_DEF,
  parameter bit IS_REST = 1'b0
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [VW-1:0]           f,
  input  wire logic signed [VW-1:0]           f_opp,
  input  wire logic signed [VW-1:0]           es,
  input  wire logic signed [VW-1:0]           ea,
  input  wire logic [d2q9_pkg::RELAX_W-1:0]   relax_even,
  input  wire logic [d2q9_pkg::RELAX_W-1:0]   relax_odd,
  output logic signed [VW-1:0]                res
);
  localparam int EW = VW + 4;
  localparam int PW = VW + d2q9_pkg::RELAX_W + 1;

  function automatic logic signed [VW-1:0] sat_v(input logic signed [EW-1:0] x);
    return signed'(VW'(d2q9_pkg::sat_w(128'(x), VW)));
  endfunction

  function automatic logic signed [VW-1:0] qshr1(input logic signed [EW-1:0] x);
    return signed'(VW'(d2q9_pkg::sat_w(d2q9_pkg::rshr(128'(x), 1), VW)));
  endfunction

  function automatic logic signed [VW-1:0] rmul(input logic [d2q9_pkg::RELAX_W-1:0] r,
                                                input logic signed [VW-1:0] d);
    logic signed [PW-1:0] p;
    p = PW'(signed'({1'b0, r})) * PW'(d);
    return signed'(VW'(d2q9_pkg::sat_w(d2q9_pkg::rshr(128'(p), FB), VW)));
  endfunction

  // Stage A: symmetric and antisymmetric deviations.
  logic signed [VW-1:0] s_a, a_a;
  always_comb begin
    if (IS_REST) begin
      s_a = f;
      a_a = '0;
    end else begin
      s_a = qshr1(EW'(f) + EW'(f_opp));
      a_a = qshr1(EW'(f) - EW'(f_opp));
    end
  end
  logic signed [VW-1:0] fa_r, dp_r, dm_r;
  always_ff @(posedge clk) begin
    if (en) begin
      fa_r <= f;
      dp_r <= sat_v(EW'(s_a) - EW'(es));
      dm_r <= sat_v(EW'(a_a) - EW'(ea));
    end
  end

  // Stage B: relaxation products.
  logic signed [VW-1:0] fb_r, pe_r, po_r;
  always_ff @(posedge clk) begin
    if (en) begin
      fb_r <= fa_r;
      pe_r <= rmul(relax_even, dp_r);
      po_r <= rmul(relax_odd, dm_r);
    end
  end

  // Stage C: post-collision value.
  logic signed [VW-1:0] res_r;
  always_ff @(posedge clk) begin
    if (en) res_r <= sat_v(EW'(fb_r) - EW'(pe_r) - EW'(po_r));
  end
  assign res = res_r;
endmodule
`default_nettype wire

@@ rtl/d2q9_merge.sv @@
// Merging stage: aligns the concentration with the lane results and holds
// the output item register. Uses d2q9_pkg and d2q9_out_if.
`default_nettype none
module d2q9_merge #(
  parameter int VW = d2q9_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire d2q9_pkg::pipe_ctl_t   ctl,
  input  wire logic signed [VW-1:0]  lane_res [d2q9_pkg::NDIR],
  input  wire logic signed [VW-1:0]  rho,
  d2q9_out_if.source                 out_ch
);
  // Concentration delay matching the three lane stages.
  logic signed [VW-1:0] rho_d_r [3];
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rho_d_r[0] <= rho;
      rho_d_r[1] <= rho_d_r[0];
      rho_d_r[2] <= rho_d_r[1];
    end
  end

  // Output item register.
  logic signed [VW-1:0] res_r [d2q9_pkg::NDIR];
  logic signed [VW-1:0] conc_r;
  logic                 valid_r;
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      res_r  <= lane_res;
      conc_r <= rho_d_r[2];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.en) begin
      valid_r <= ctl.vld;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.out_rest      = res_r[0];
  assign out_ch.out_east      = res_r[1];
  assign out_ch.out_north     = res_r[2];
  assign out_ch.out_west      = res_r[3];
  assign out_ch.out_south     = res_r[4];
  assign out_ch.out_northeast = res_r[5];
  assign out_ch.out_northwest = res_r[6];
  assign out_ch.out_southwest = res_r[7];
  assign out_ch.out_southeast = res_r[8];
  assign out_ch.concentration = conc_r;
endmodule
`default_nettype wire

@@ tb/d2q9_collision_checker.sv @@
// Result checker for the D2Q9 TRT collision unit: watches both channels,
// predicts each node's post-collision populations and compares them.
// Depends on d2q9_in_if and d2q9_out_if.
`timescale 1ns / 1ps
module d2q9_collision_checker (
  input  logic             clk,
  input  logic             rst_n,
  d2q9_in_if.sink          node_mon,
  d2q9_out_if.sink         coll_mon,
  input  logic [21:0]      relax_even,
  input  logic [21:0]      relax_odd,
  input  logic [20:0]      diffusion_scale,
  output int               fail_count,
  output int               pending_count,
  output int               results_seen
);
  localparam longint VMAX = (64'sd1 <<< 23) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint ONE_Q = 64'sd1 <<< 20;
  localparam longint C_THIRD = (2 * ONE_Q + 3) / 6;
  localparam longint C_TWELFTH = (2 * ONE_Q + 12) / 24;

  typedef logic signed [23:0] q_t;
  typedef struct packed {
    q_t [8:0] pop;
    q_t       conc;
  } node_result_t;

  node_result_t expected_nodes[$];

  // Clamp to the 24-bit signed range.
  function automatic longint clamp(input longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  // Divide by 2^n, rounding half away from zero, then clamp.
  function automatic longint round_shift(input longint x, input int n);
    longint m, r;
    m = (x < 0) ? -x : x;
    r = (m >>> n) + ((m >>> (n - 1)) & 1);
    return clamp((x < 0) ? -r : r);
  endfunction

  // Fixed-point product, rounded half away from zero, clamped.
  function automatic longint fx_mul(input longint a, input longint b);
    logic signed [127:0] p, m, r;
    p = 128'(a) * 128'(b);
    m = (p < 0) ? -p : p;
    r = (m + (128'sd1 <<< 19)) >>> 20;
    if (p < 0) r = -r;
    if (r > VMAX) return VMAX;
    if (r < VMIN) return VMIN;
    return longint'(r);
  endfunction

  function automatic node_result_t collide(input longint f[9], input longint ux,
                                           input longint uy);
    node_result_t res;
    longint s[9], a[9], es[9], ea[9];
    longint acc, rho, uxx, uyy, uxy, usq, umn, base, rb, ax, dg, qmn, qcr, dp, dm;
    acc = 0;
    for (int k = 0; k < 9; k++) acc += f[k];
    rho = clamp(acc);
    // Split into symmetric and antisymmetric halves about opposite directions.
    s[0] = f[0];
    a[0] = 0;
    s[1] = round_shift(f[1] + f[3], 1); s[3] = s[1];
    s[2] = round_shift(f[2] + f[4], 1); s[4] = s[2];
    s[5] = round_shift(f[5] + f[7], 1); s[7] = s[5];
    s[6] = round_shift(f[6] + f[8], 1); s[8] = s[6];
    a[1] = round_shift(f[1] - f[3], 1); a[3] = round_shift(f[3] - f[1], 1);
    a[2] = round_shift(f[2] - f[4], 1); a[4] = round_shift(f[4] - f[2], 1);
    a[5] = round_shift(f[5] - f[7], 1); a[7] = round_shift(f[7] - f[5], 1);
    a[6] = round_shift(f[6] - f[8], 1); a[8] = round_shift(f[8] - f[6], 1);
    // Equilibria.
    uxx = fx_mul(ux, ux);
    uyy = fx_mul(uy, uy);
    uxy = fx_mul(ux, uy);
    usq = clamp(uxx + uyy);
    umn = clamp(uxx - uyy);
    base = clamp(longint'(diffusion_scale) + round_shift(usq, 1));
    rb = fx_mul(rho, base);
    ax = fx_mul(C_THIRD, rb);
    dg = fx_mul(C_TWELFTH, rb);
    qmn = round_shift(fx_mul(rho, umn), 2);
    qcr = round_shift(fx_mul(rho, uxy), 2);
    es[1] = clamp(ax + qmn); es[3] = es[1];
    es[2] = clamp(ax - qmn); es[4] = es[2];
    es[5] = clamp(dg + qcr); es[7] = es[5];
    es[6] = clamp(dg - qcr); es[8] = es[6];
    es[0] = clamp(rho - 2 * (es[1] + es[2] + es[5] + es[6]));
    ea[0] = 0;
    ea[1] = fx_mul(C_THIRD, fx_mul(rho, ux));
    ea[2] = fx_mul(C_THIRD, fx_mul(rho, uy));
    ea[5] = fx_mul(C_TWELFTH, fx_mul(rho, clamp(ux + uy)));
    ea[6] = fx_mul(C_TWELFTH, fx_mul(rho, clamp(uy - ux)));
    ea[3] = clamp(-ea[1]);
    ea[4] = clamp(-ea[2]);
    ea[7] = clamp(-ea[5]);
    ea[8] = clamp(-ea[6]);
    // Relax both parts.
    for (int k = 0; k < 9; k++) begin
      dp = clamp(s[k] - es[k]);
      dm = clamp(a[k] - ea[k]);
      res.pop[k] = q_t'(clamp(f[k] - fx_mul(longint'(relax_even), dp)
                               - fx_mul(longint'(relax_odd), dm)));
    end
    res.conc = q_t'(rho);
    return res;
  endfunction

  assign pending_count = expected_nodes.size();

  // Predict on every accepted node and compare every accepted result.
  always @(posedge clk) begin
    longint f[9];
    node_result_t got, want, pred;
    int errs;
    if (!rst_n) begin
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      errs = 0;
      if (node_mon.valid && node_mon.ready) begin
        f[0] = node_mon.pop_rest;      f[1] = node_mon.pop_east;
        f[2] = node_mon.pop_north;     f[3] = node_mon.pop_west;
        f[4] = node_mon.pop_south;     f[5] = node_mon.pop_northeast;
        f[6] = node_mon.pop_northwest; f[7] = node_mon.pop_southwest;
        f[8] = node_mon.pop_southeast;
        pred = collide(f, node_mon.vel_x, node_mon.vel_y);
        expected_nodes.insert(expected_nodes.size(), pred);
      end
      if (coll_mon.valid && coll_mon.ready) begin
        got.pop[0] = coll_mon.out_rest;      got.pop[1] = coll_mon.out_east;
        got.pop[2] = coll_mon.out_north;     got.pop[3] = coll_mon.out_west;
        got.pop[4] = coll_mon.out_south;     got.pop[5] = coll_mon.out_northeast;
        got.pop[6] = coll_mon.out_northwest; got.pop[7] = coll_mon.out_southwest;
        got.pop[8] = coll_mon.out_southeast; got.conc = coll_mon.concentration;
        results_seen <= results_seen + 1;
        if (expected_nodes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
          errs = errs + 1;
        end else begin
          want = expected_nodes.pop_front();
          for (int k = 0; k < 9; k++)
            if (got.pop[k] !== want.pop[k]) begin
              $display("%0t: direction %0d expected %0d got %0d", $time, k,
                       want.pop[k], got.pop[k]);
              errs = errs + 1;
            end
          if (got.conc !== want.conc) begin
            $display("%0t: concentration expected %0d got %0d", $time,
                     want.conc, got.conc);
            errs = errs + 1;
          end
        end
      end
      // One update per cycle, however many fields disagreed.
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

@@ tb/tb_d2q9_trt_collision_unit.sv @@
// Top of the D2Q9 TRT collision unit testbench: clock, reset, register
// writes, node stimulus and verdict. Depends on the RTL and the checker.
`timescale 1ns / 1ps
module tb_d2q9_trt_collision_unit;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic signed [23:0] QMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] QMIN = -24'sh800000;

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [d2q9_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic [21:0] relax_even, relax_odd;
  logic [20:0] diffusion_scale;
  int fail_count, pending_count, results_seen, nodes_sent, idle_cycles;
  int send_idle_pct, recv_idle_pct, recv_hold;
  bit finished;

  d2q9_in_if  #(24) node_ch ();
  d2q9_out_if #(24) coll_ch ();

  d2q9_trt_collision_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(node_ch), .out_ch(coll_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  d2q9_collision_checker u_checker (
    .clk(clk), .rst_n(rst_n), .node_mon(node_ch), .coll_mon(coll_ch),
    .relax_even(relax_even), .relax_odd(relax_odd),
    .diffusion_scale(diffusion_scale), .fail_count(fail_count),
    .pending_count(pending_count), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, with an optional long hold-off.
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      coll_ch.ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      coll_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog over cycles with no accepted item and no receiver hold-off.
  always @(posedge clk) begin
    if ((node_ch.valid && node_ch.ready) || (coll_ch.valid && coll_ch.ready) ||
        recv_hold > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT && !finished) begin
      $display("d2q9_trt_collision_unit test failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    case (idx)
      d2q9_pkg::REG_RELAX_EVEN: relax_even = value[21:0];
      d2q9_pkg::REG_RELAX_ODD:  relax_odd = value[21:0];
      default:                  diffusion_scale = value[20:0];
    endcase
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_rates(input logic [31:0] ev, input logic [31:0] od,
                           input logic [31:0] ce);
    reg_write(d2q9_pkg::REG_RELAX_EVEN, ev);
    reg_write(d2q9_pkg::REG_RELAX_ODD, od);
    reg_write(d2q9_pkg::REG_DIFFUSION, ce);
  endtask

  // Offer one node and hold it until accepted.
  task automatic send_node(input logic signed [23:0] p[9],
                           input logic signed [23:0] vx,
                           input logic signed [23:0] vy);
    while ($urandom_range(99) < send_idle_pct) begin
      node_ch.valid <= 0;
      @(negedge clk);
    end
    node_ch.valid <= 1;
    node_ch.pop_rest <= p[0];      node_ch.pop_east <= p[1];
    node_ch.pop_north <= p[2];     node_ch.pop_west <= p[3];
    node_ch.pop_south <= p[4];     node_ch.pop_northeast <= p[5];
    node_ch.pop_northwest <= p[6]; node_ch.pop_southwest <= p[7];
    node_ch.pop_southeast <= p[8];
    node_ch.vel_x <= vx; node_ch.vel_y <= vy;
    do @(posedge clk); while (!(node_ch.valid && node_ch.ready));
    nodes_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    node_ch.valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  // Random value: mostly physical magnitudes, sometimes full-range or extremes.
  function automatic logic signed [23:0] rand_q(input int mode);
    case ($urandom_range(9))
      0: return $urandom_range(1) ? QMAX : QMIN;
      1, 2: return 24'($urandom);
      default: return mode ? 24'($signed($urandom_range(409600)) - 204800)
                           : 24'($urandom_range(262144));
    endcase
  endfunction

  task automatic random_nodes(input int count);
    logic signed [23:0] p[9];
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 9; k++) p[k] = rand_q(0);
      send_node(p, rand_q(1), rand_q(1));
    end
  endtask

  initial begin
    logic signed [23:0] p[9];
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    node_ch.valid = 0; coll_ch.ready = 0; recv_hold = 0; finished = 0;
    node_ch.pop_rest = 0; node_ch.pop_east = 0; node_ch.pop_north = 0;
    node_ch.pop_west = 0; node_ch.pop_south = 0; node_ch.pop_northeast = 0;
    node_ch.pop_northwest = 0; node_ch.pop_southwest = 0;
    node_ch.pop_southeast = 0; node_ch.vel_x = 0; node_ch.vel_y = 0;
    relax_even = 22'd10486; relax_odd = 22'd2086666; diffusion_scale = 21'd349525;
    send_idle_pct = 6; recv_idle_pct = 57; nodes_sent = 0; idle_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed nodes at reset rates: zeros, extremes, overflowing sums.
    for (int k = 0; k < 9; k++) p[k] = 0;
    send_node(p, 0, 0);
    for (int k = 0; k < 9; k++) p[k] = QMAX;
    send_node(p, QMAX, QMAX);
    for (int k = 0; k < 9; k++) p[k] = QMIN;
    send_node(p, QMIN, QMIN);
    send_node(p, QMAX, QMIN);
    for (int k = 0; k < 9; k++) p[k] = k[0] ? QMAX : QMIN;
    send_node(p, QMIN, QMAX);
    for (int k = 0; k < 9; k++) p[k] = 24'sd116508;
    send_node(p, 24'sd52429, -24'sd31457);
    for (int k = 0; k < 9; k++) p[k] = k[0] ? 24'sh555555 : 24'shAAAAAA;
    send_node(p, 24'sh2AAAAA, -24'sh155555);
    for (int k = 0; k < 9; k++) p[k] = 24'sd1;
    send_node(p, -24'sd1, 24'sd1);
    for (int k = 0; k < 9; k++) p[k] = -24'sd1;
    send_node(p, 24'sd1048576, -24'sd1048576);
    random_nodes(10);
    drain();

    // Extreme rates, out-of-range written values, then random and reset rates.
    set_rates(32'd0, 32'd0, 32'd0);
    random_nodes(100);
    drain();
    set_rates(32'd2097152, 32'd2097152, 32'd1048576);
    random_nodes(150);
    // Long receiver hold-off while the sender keeps offering.
    recv_hold = 200;
    random_nodes(100);
    drain();
    set_rates(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    random_nodes(150);
    drain();
    send_idle_pct = 57; recv_idle_pct = 6;
    set_rates($urandom_range(2097152), $urandom_range(2097152),
              $urandom_range(1048576));
    random_nodes(500);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_rates(32'd10486, 32'd2086666, 32'd349525);
    random_nodes(450);
    drain();
    set_rates($urandom_range(2097152), $urandom_range(2097152),
              $urandom_range(1048576));
    random_nodes(480);
    drain();

    finished = 1;
    $display("Sent %0d nodes, checked %0d results over seven register settings,",
             nodes_sent, results_seen);
    $display("including zero, full-scale and overwide rates and long stalls.");
    if (fail_count == 0 && pending_count == 0)
      $display("d2q9_trt_collision_unit test passed");
    else
      $display("d2q9_trt_collision_unit test failed");
    $finish;
  end
endmodule
